// File: design/prime_sieve_table_macros.svh
// ---------------------------------------------------------------------------
// prime_sieve_table_macros
// Assertion macros shared by the prime sieve table design files.
// ---------------------------------------------------------------------------
`ifndef PRIME_SIEVE_TABLE_MACROS_SVH
`define PRIME_SIEVE_TABLE_MACROS_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define PST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("prime_sieve_table: same-cycle check failed");

// Next-cycle implication, checked on aclk outside of reset.
`define PST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("prime_sieve_table: next-cycle check failed");

`endif

// File: design/pst_pkg.sv
// ---------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the prime sieve table.
// ---------------------------------------------------------------------------
package pst_pkg;

    localparam int TABLE_SIZE_DEF = 16384;

    localparam int LIMIT_W    = 15;
    localparam int QUERY_W    = 14;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

    // Register index of table_limit, taken from paddr[2].
    localparam logic REG_TABLE_LIMIT = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic {
        CMD_BUILD = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        SV_IDLE,
        SV_INIT,
        SV_READ,
        SV_CHECK,
        SV_CLEAR,
        SV_FINISH
    } sieve_state_t;

    typedef struct packed {
        logic we;
        logic re;
        logic wdata;
    } ram_ctl_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } sieve_stat_t;

endpackage

// File: design/pst_flag_ram.sv
// ---------------------------------------------------------------------------
// pst_flag_ram
// Single-port 1-bit flag memory with a registered read port.
// ---------------------------------------------------------------------------
module pst_flag_ram
    import pst_pkg::*;
#(
    parameter int DEPTH = TABLE_SIZE_DEF,
    parameter int AW    = $clog2(TABLE_SIZE_DEF)
) (
    input  logic          aclk,
    input  ram_ctl_t      ctl,
    input  logic [AW-1:0] addr,
    output logic          rdata
);

    logic flag_mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            flag_mem[addr] <= ctl.wdata;
        end
    end

    // Read data holds until the next read, so a stalled reader keeps its value.
    always_ff @(posedge aclk) begin
        if (ctl.re) begin
            rdata_reg <= flag_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pst_sieve_ctrl.sv
// ---------------------------------------------------------------------------
// pst_sieve_ctrl
// Sequencer that fills the flag memory and strikes out composite numbers.
// ---------------------------------------------------------------------------
module pst_sieve_ctrl
    import pst_pkg::*;
#(
    parameter int AW = $clog2(TABLE_SIZE_DEF),
    parameter int LW = $clog2(TABLE_SIZE_DEF + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [LW-1:0] eff_limit,
    input  logic          finish_ack,
    input  logic          ram_rdata,
    output ram_ctl_t      ram_ctl,
    output logic [AW-1:0] ram_addr,
    output sieve_stat_t   stat
);

    // Counters hold values up to twice the limit.
    localparam int SQW = LW + 1;

    sieve_state_t   state_reg, state_next;
    logic [LW-1:0]  lim_reg, lim_next;
    logic [SQW-1:0] i_reg, i_next;
    logic [SQW-1:0] sq_reg, sq_next;
    logic [SQW-1:0] j_reg, j_next;

    logic [SQW-1:0] lim_ext;
    logic [SQW-1:0] j_inc;
    logic [SQW-1:0] j_step;
    logic [SQW-1:0] sq_step;

    assign lim_ext = {1'b0, lim_reg};
    assign j_inc   = j_reg + SQW'(1);
    assign j_step  = j_reg + i_reg;
    // (i+1)^2 = i^2 + 2i + 1
    assign sq_step = sq_reg + {i_reg[SQW-2:0], 1'b0} + SQW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg <= lim_next;
        i_reg   <= i_next;
        sq_reg  <= sq_next;
        j_reg   <= j_next;
    end

    always_comb begin
        state_next  = state_reg;
        lim_next    = lim_reg;
        i_next      = i_reg;
        sq_next     = sq_reg;
        j_next      = j_reg;
        ram_ctl     = '0;
        ram_addr    = j_reg[AW-1:0];
        stat.busy   = (state_reg != SV_IDLE);
        stat.finish = 1'b0;

        case (state_reg)
            SV_IDLE: begin
                if (start) begin
                    lim_next   = eff_limit;
                    j_next     = '0;
                    state_next = SV_INIT;
                end
            end
            SV_INIT: begin
                // Zero and one are not prime; everything else starts as prime.
                ram_ctl.we    = 1'b1;
                ram_ctl.wdata = (j_reg >= SQW'(2));
                j_next        = j_inc;
                if (j_inc == lim_ext) begin
                    i_next     = SQW'(2);
                    sq_next    = SQW'(4);
                    state_next = (SQW'(4) < lim_ext) ? SV_READ : SV_FINISH;
                end
            end
            SV_READ: begin
                ram_ctl.re = 1'b1;
                ram_addr   = i_reg[AW-1:0];
                state_next = SV_CHECK;
            end
            SV_CHECK: begin
                if (ram_rdata) begin
                    j_next     = sq_reg;
                    state_next = SV_CLEAR;
                end else begin
                    i_next     = i_reg + SQW'(1);
                    sq_next    = sq_step;
                    state_next = (sq_step < lim_ext) ? SV_READ : SV_FINISH;
                end
            end
            SV_CLEAR: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.wdata = 1'b0;
                if (j_step < lim_ext) begin
                    j_next = j_step;
                end else begin
                    i_next     = i_reg + SQW'(1);
                    sq_next    = sq_step;
                    state_next = (sq_step < lim_ext) ? SV_READ : SV_FINISH;
                end
            end
            SV_FINISH: begin
                stat.finish = 1'b1;
                if (finish_ack) begin
                    state_next = SV_IDLE;
                end
            end
            default: begin
                state_next = SV_IDLE;
            end
        endcase
    end

endmodule

// File: design/prime_sieve_table.sv
// ---------------------------------------------------------------------------
// prime_sieve_table
// Primality bit table built by the Sieve of Eratosthenes, answering queries.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid / s_tready  s_tuser: cmd, s_tdata: query_number
//  m_        out        m_tvalid / m_tready  m_tdata: is_prime, status
//  APB       in         psel/penable/pready  table_limit at byte address 0
//
//  A query is a single read of the flag memory; its flag is registered in
//  the memory beside stage one and then in the output register, and queries
//  can be accepted back to back while the output register drains.
//  A build runs in the sieve sequencer: it fills the table up to L (the
//  effective limit), reads and checks each candidate i with i*i < L,
//  strikes out the multiples of each prime, and hands over its transaction.
//  Reset is synchronous and active low; the flag memory is not cleared, as
//  no query can reach it before a build. s_tready is low during a build and
//  whenever the output stage cannot drain.
// ---------------------------------------------------------------------------
`include "prime_sieve_table_macros.svh"

module prime_sieve_table
    import pst_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [13:0] query_number, [15:14] zero
    input  logic [0:0]            s_tuser,   // [0] cmd
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [0] is_prime, [2:1] status, [7:3] zero
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int LW = $clog2(TABLE_SIZE + 1);
    localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               built_reg, built_next;
    logic               s1_valid_reg, s1_valid_next;
    status_t            s1_status_reg, s1_status_next;
    logic               s1_mem_reg, s1_mem_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_is_prime_reg, m_is_prime_next;
    status_t            m_status_reg, m_status_next;

    logic               cfg_wr;
    logic [CW-1:0]      limit_ext;
    logic [CW-1:0]      eff_lim_cw;
    logic [CW-1:0]      num_ext;
    logic               s_fire;
    logic               is_query;
    logic               in_range;
    logic               s1_adv;
    logic               s1_free;
    logic               s1_load;
    logic               finish_ack;
    logic               start;

    ram_ctl_t           ctrl_ram_ctl;
    logic [AW-1:0]      ctrl_ram_addr;
    ram_ctl_t           ram_ctl;
    logic [AW-1:0]      ram_addr;
    logic               ram_rdata;
    sieve_stat_t        stat;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {{(APB_DATA_W - LIMIT_W){1'b0}}, limit_reg};

    // Effective limit, saturated into 2 .. TABLE_SIZE.
    assign limit_ext = CW'(limit_reg);
    always_comb begin
        if (limit_ext < CW'(2)) begin
            eff_lim_cw = CW'(2);
        end else if (limit_ext > CW'(TABLE_SIZE)) begin
            eff_lim_cw = CW'(TABLE_SIZE);
        end else begin
            eff_lim_cw = limit_ext;
        end
    end

    // Input side
    assign num_ext  = CW'(s_tdata[QUERY_W-1:0]);
    assign is_query = (cmd_t'(s_tuser[0]) == CMD_QUERY);
    assign in_range = (num_ext < eff_lim_cw);
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign s_tready = !stat.busy && s1_free;
    assign s_fire   = s_tvalid && s_tready;
    assign start    = s_fire && !is_query;

    assign finish_ack = stat.finish && s1_free;
    assign s1_load    = (s_fire && is_query) || finish_ack;

    // The sequencer owns the memory during a build; queries use it otherwise.
    always_comb begin
        if (stat.busy) begin
            ram_ctl  = ctrl_ram_ctl;
            ram_addr = ctrl_ram_addr;
        end else begin
            ram_ctl.we    = 1'b0;
            ram_ctl.wdata = 1'b0;
            ram_ctl.re    = s_fire && is_query && built_reg && in_range;
            ram_addr      = num_ext[AW-1:0];
        end
    end

    pst_sieve_ctrl #(
        .AW (AW),
        .LW (LW)
    ) u_sieve_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .eff_limit  (eff_lim_cw[LW-1:0]),
        .finish_ack (finish_ack),
        .ram_rdata  (ram_rdata),
        .ram_ctl    (ctrl_ram_ctl),
        .ram_addr   (ctrl_ram_addr),
        .stat       (stat)
    );

    pst_flag_ram #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_flag_ram (
        .aclk  (aclk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        limit_next      = limit_reg;
        built_next      = built_reg;
        s1_valid_next   = s1_valid_reg;
        s1_status_next  = s1_status_reg;
        s1_mem_next     = s1_mem_reg;
        m_valid_next    = m_valid_reg;
        m_is_prime_next = m_is_prime_reg;
        m_status_next   = m_status_reg;

        if (cfg_wr && (paddr[2] == REG_TABLE_LIMIT)) begin
            limit_next = pwdata[LIMIT_W-1:0];
            built_next = 1'b0;
        end else if (finish_ack) begin
            built_next = 1'b1;
        end

        // Stage one: status decided, flag read in flight when needed.
        if (s1_load) begin
            s1_valid_next = 1'b1;
            if (finish_ack) begin
                s1_status_next = ST_OK;
                s1_mem_next    = 1'b0;
            end else if (!built_reg) begin
                s1_status_next = ST_NOT_BUILT;
                s1_mem_next    = 1'b0;
            end else if (!in_range) begin
                s1_status_next = ST_RANGE;
                s1_mem_next    = 1'b0;
            end else begin
                s1_status_next = ST_OK;
                s1_mem_next    = 1'b1;
            end
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        // Output register.
        if (s1_adv) begin
            m_valid_next    = 1'b1;
            m_is_prime_next = s1_mem_reg && ram_rdata;
            m_status_next   = s1_status_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= LIMIT_RESET;
            built_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            limit_reg    <= limit_next;
            built_reg    <= built_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_status_reg  <= s1_status_next;
        s1_mem_reg     <= s1_mem_next;
        m_is_prime_reg <= m_is_prime_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - 1){1'b0}}, m_status_reg, m_is_prime_reg};

    // A new transaction is never taken while the sieve owns the memory.
    `PST_ASSERT_IMPL(a_ready_not_busy, s_tready, !stat.busy)
    // A stalled first stage relies on the memory keeping its read data.
    `PST_ASSERT_IMPL(a_rdata_held, s1_valid_reg && !s1_adv, !ram_ctl.re)
    // A held result in the first stage is never overwritten.
    `PST_ASSERT_IMPL(a_s1_no_overwrite, s1_valid_reg && !s1_adv, !s1_load)
    // Writing the limit always invalidates the table.
    `PST_ASSERT_NEXT(a_limit_unbuilds, cfg_wr && (paddr[2] == REG_TABLE_LIMIT), !built_reg)

endmodule

// File: bench/prime_sieve_table_checker.sv
// ---------------------------------------------------------------------------
// prime_sieve_table_checker
// Watches the configuration port and both streams of the prime sieve table,
// keeps its own primality table and limit register, and compares every
// result transaction with the oldest predicted answer.
// ---------------------------------------------------------------------------
module prime_sieve_table_checker
    import pst_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [13:0] query_number, [15:14] zero
    input  logic [0:0]            s_tuser,   // [0] cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [0] is_prime, [2:1] status, [7:3] zero
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        status_t status;
        logic    is_prime;
    } answer_t;

    logic [LIMIT_W-1:0] limit_reg;
    bit                 built;
    bit                 flags [0:TABLE_SIZE-1];
    answer_t            answer_q [$];
    int                 errors = 0;

    // Limit actually covered by the table, saturated into 2..TABLE_SIZE.
    function automatic int table_span();
        int lim;
        lim = int'(limit_reg);
        if (lim < 2)
            lim = 2;
        if (lim > TABLE_SIZE)
            lim = TABLE_SIZE;
        return lim;
    endfunction

    function automatic void sieve_fill();
        int lim;
        int i;
        int j;
        lim = table_span();
        flags[0] = 1'b0;
        flags[1] = 1'b0;
        for (i = 2; i < lim; i++)
            flags[i] = 1'b1;
        for (i = 2; i * i < lim; i++) begin
            if (flags[i]) begin
                for (j = i * i; j < lim; j += i)
                    flags[j] = 1'b0;
            end
        end
        built = 1'b1;
    endfunction

    function automatic answer_t predict_answer(cmd_t cmd, logic [QUERY_W-1:0] num);
        answer_t a;
        a.is_prime = 1'b0;
        a.status   = ST_OK;
        if (cmd == CMD_BUILD)
            sieve_fill();
        else if (!built)
            a.status = ST_NOT_BUILT;
        else if (int'(num) >= table_span())
            a.status = ST_RANGE;
        else
            a.is_prime = flags[num];
        return a;
    endfunction

    function automatic void report(string what, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            limit_reg = LIMIT_RESET;
            built     = 1'b0;
            answer_q.delete();
        end else begin
            if (psel && penable && pready && paddr[2] == REG_TABLE_LIMIT) begin
                if (pwrite) begin
                    limit_reg = pwdata[LIMIT_W-1:0];
                    built     = 1'b0;
                end else if (prdata[LIMIT_W-1:0] !== limit_reg) begin
                    report("table_limit readback", int'(limit_reg),
                           int'(prdata[LIMIT_W-1:0]));
                end
            end

            if (s_tvalid && s_tready)
                answer_q.push_back(predict_answer(cmd_t'(s_tuser[0]), s_tdata[QUERY_W-1:0]));

            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    errors++;
                    $display("%0t: result mismatch, expected no transaction, got 0x%0h",
                             $time, m_tdata);
                end else begin
                    want = answer_q.pop_front();
                    if (m_tdata[0] !== want.is_prime)
                        report("is_prime", int'(want.is_prime), int'(m_tdata[0]));
                    if (m_tdata[2:1] !== want.status)
                        report("status", int'(want.status), int'(m_tdata[2:1]));
                end
            end
        end
        fail_count  <= errors;
        outstanding <= answer_q.size();
    end

endmodule

// File: bench/prime_sieve_table_tb.sv
// ---------------------------------------------------------------------------
// prime_sieve_table_tb
// Drives builds and queries into the prime sieve table under a series of
// limit settings, with random gaps on both streams and one long output stall;
// the checker beside the block predicts and compares every answer.
// ---------------------------------------------------------------------------
module prime_sieve_table_tb;
    import pst_pkg::*;

    localparam int TOTAL_ITEMS  = 1050;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_NUMBER   = (1 << QUERY_W) - 1;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_TABLE_LIMIT, 2'b00};

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [13:0] query_number, [15:14] zero
    logic [0:0]            s_tuser  = '0;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [0] is_prime, [2:1] status, [7:3] zero

    int fail_count;
    int outstanding;
    int items_sent    = 0;
    int results_seen  = 0;
    int builds_sent   = 0;
    int queries_sent  = 0;
    int limit_writes  = 0;
    int cycle_count   = 0;
    int big_left      = 1;
    bit tx_fast       = 1'b0;
    bit rx_fast       = 1'b0;

    prime_sieve_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    prime_sieve_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles.", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Optional write of table_limit followed by a readback of it.
    task automatic program_limit(input bit do_write, input logic [APB_DATA_W-1:0] value);
        if (do_write) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= LIMIT_ADDR;
            pwdata  <= value;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            limit_writes++;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LIMIT_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Leaves tvalid high after acceptance so that a zero gap gives back to
    // back transactions; callers lower it when the burst ends.
    task automatic send_item(input cmd_t cmd, input int num);
        int                 gap;
        logic [QUERY_W-1:0] q;
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        q   = QUERY_W'(num);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-QUERY_W){1'b0}}, q};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (cmd == CMD_BUILD)
            builds_sent++;
        else
            queries_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
    endtask

    task automatic random_phase(input int raw);
        int span;
        int n;
        int r;
        int num;
        span = (raw < 2) ? 2 : ((raw > TABLE_SIZE_DEF) ? TABLE_SIZE_DEF : raw);
        settle();
        program_limit(1'b1, ($urandom() & 32'hFFFF_8000) | raw);
        tx_fast = ($urandom_range(0, 3) == 0);
        // A few queries against the freshly cleared table.
        repeat ($urandom_range(0, 2)) send_item(CMD_QUERY, $urandom_range(0, MAX_NUMBER));
        send_item(CMD_BUILD, $urandom_range(0, MAX_NUMBER));
        n = $urandom_range(20, 50);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(CMD_BUILD, $urandom_range(0, MAX_NUMBER));
            end else if (r < 83) begin
                send_item(CMD_QUERY, $urandom_range(0, span - 1));
            end else if (r < 93) begin
                num = span - 1 + $urandom_range(0, 2);
                send_item(CMD_QUERY, (num > MAX_NUMBER) ? MAX_NUMBER : num);
            end else begin
                send_item(CMD_QUERY, $urandom_range(0, MAX_NUMBER));
            end
        end
    endtask

    // Output side: random gaps, occasional stretches without any, and one
    // long stall that backs the block up into its input.
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_seen % 97 == 0)
                rx_fast = ($urandom_range(0, 2) == 0);
            if (results_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (rx_fast)
                gap = 0;
            else
                gap = $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
        end
    end

    initial begin
        int raw;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limit, before and after the first build.
        program_limit(1'b0, '0);
        send_item(CMD_QUERY, 0);
        send_item(CMD_QUERY, MAX_NUMBER);
        send_item(CMD_BUILD, 0);
        send_item(CMD_QUERY, 0);
        send_item(CMD_QUERY, 1);
        send_item(CMD_QUERY, 2);
        send_item(CMD_QUERY, 4);
        send_item(CMD_QUERY, 16381);
        send_item(CMD_QUERY, MAX_NUMBER);
        settle();

        // A limit below two acts as two.
        program_limit(1'b1, 32'd0);
        send_item(CMD_QUERY, 5);
        send_item(CMD_BUILD, MAX_NUMBER);
        send_item(CMD_QUERY, 0);
        send_item(CMD_QUERY, 1);
        send_item(CMD_QUERY, 2);
        settle();

        program_limit(1'b1, 32'd3);
        send_item(CMD_BUILD, 0);
        send_item(CMD_QUERY, 2);
        send_item(CMD_QUERY, 3);
        settle();

        // All ones on the bus: the limit saturates to the table size.
        program_limit(1'b1, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 7);
        send_item(CMD_BUILD, 0);
        send_item(CMD_QUERY, MAX_NUMBER);
        send_item(CMD_QUERY, 8191);
        settle();

        program_limit(1'b1, 32'd2);
        send_item(CMD_BUILD, 0);
        send_item(CMD_QUERY, 1);
        send_item(CMD_QUERY, 2);

        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 99) < 6) begin
                case ($urandom_range(0, 6))
                    0: raw = 0;
                    1: raw = 1;
                    2: raw = 2;
                    3: raw = 3;
                    4: raw = TABLE_SIZE_DEF - 1;
                    5: raw = TABLE_SIZE_DEF;
                    default: raw = $urandom_range(TABLE_SIZE_DEF + 1, (1 << LIMIT_W) - 1);
                endcase
                // Full-size builds are slow, so only one is allowed here.
                if (raw > 2500) begin
                    if (big_left > 0)
                        big_left--;
                    else
                        raw = $urandom_range(2, 300);
                end
            end else if ($urandom_range(0, 99) < 17) begin
                raw = $urandom_range(300, 2500);
            end else begin
                raw = $urandom_range(2, 300);
            end
            random_phase(raw);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d builds and %0d queries under %0d limit writes.",
                 builds_sent, queries_sent, limit_writes);
        $display("%0d result transactions were checked in %0d cycles.", results_seen, cycle_count);
        if (outstanding != 0)
            $display("%0d expected results never arrived.", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/pst_pkg.sv
design/pst_flag_ram.sv
design/pst_sieve_ctrl.sv
design/prime_sieve_table.sv
bench/prime_sieve_table_checker.sv
bench/prime_sieve_table_tb.sv
